[rtl/core/imh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package imh_pkg;

  // Sizing of the heap, the label space and the height key.
  localparam int HeapDepth  = 255;
  localparam int LabelCount = 256;
  localparam int HeightW    = 16;

  localparam int LabelW = $clog2(LabelCount);
  localparam int CountW = $clog2(HeapDepth + 1);
  localparam int KeyW   = HeightW + LabelW;

  // Request codes.
  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  // Status codes reported with every result.
  localparam logic [1:0] StatusOk         = 2'd0;
  localparam logic [1:0] StatusFull       = 2'd1;
  localparam logic [1:0] StatusNotPresent = 2'd2;
  localparam logic [1:0] StatusBadLabel   = 2'd3;

  // One slot of the sorted chain.
  typedef struct packed {
    logic               valid;
    logic [HeightW-1:0] height;
    logic [LabelW-1:0]  label;
  } cell_t;

  // Operation that all cells of the chain perform in the same cycle.
  typedef enum logic [1:0] {
    CmdHold,
    CmdInsert,
    CmdRemove
  } chain_cmd_e;

  // Command and key broadcast to every cell.
  typedef struct packed {
    chain_cmd_e      cmd;
    logic [KeyW-1:0] key;
  } chain_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/imh_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One slot of the chain. The chain is kept sorted in descending order of
// the key {height, label}, valid entries packed toward slot 0. Since labels
// are unique, every key in the chain is unique.
module imh_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire imh_pkg::chain_ctrl_t ctrl_i,
  input  wire imh_pkg::cell_t      left_i,
  input  wire logic                left_gt_i,
  input  wire imh_pkg::cell_t      right_i,
  output imh_pkg::cell_t           entry_o,
  output logic                     gt_o
);

  imh_pkg::cell_t entry_q, entry_d;
  logic [imh_pkg::KeyW-1:0] own_key;
  logic                     le_key;

  // Compare the held key with the broadcast key.
  assign own_key = {entry_q.height, entry_q.label};
  assign gt_o    = entry_q.valid && (own_key > ctrl_i.key);
  assign le_key  = entry_q.valid && !(own_key > ctrl_i.key);

  // Insert shifts the smaller part of the chain one slot toward the tail;
  // remove pulls every entry at or below the removed key one slot forward.
  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.cmd)
      imh_pkg::CmdInsert: begin
        if (!gt_o) begin
          if (left_gt_i) begin
            entry_d.valid  = 1'b1;
            entry_d.height = ctrl_i.key[imh_pkg::KeyW-1:imh_pkg::LabelW];
            entry_d.label  = ctrl_i.key[imh_pkg::LabelW-1:0];
          end else begin
            entry_d = left_i;
          end
        end
      end
      imh_pkg::CmdRemove: begin
        if (le_key) begin
          entry_d = right_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

[rtl/core/imh_chain.sv]
`timescale 1ns / 1ps
`default_nettype none

// Row of slots. Each slot sees its neighbors' entries and the left
// neighbor's compare result, so all slots settle a whole insert or remove together.
module imh_chain (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire imh_pkg::chain_ctrl_t ctrl_i,
  output imh_pkg::cell_t            head_o,
  output logic                      full_o
);

  imh_pkg::cell_t entries [imh_pkg::HeapDepth];
  logic           gt      [imh_pkg::HeapDepth];

  for (genvar i = 0; i < imh_pkg::HeapDepth; i++) begin : g_cell
    imh_pkg::cell_t left_w;
    imh_pkg::cell_t right_w;
    logic           left_gt_w;

    // The head has nothing ahead of it that could be larger.
    if (i == 0) begin : g_first
      assign left_w    = '0;
      assign left_gt_w = 1'b1;
    end else begin : g_next
      assign left_w    = entries[i-1];
      assign left_gt_w = gt[i-1];
    end

    // Past the tail lies an empty slot.
    if (i == imh_pkg::HeapDepth - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = entries[i+1];
    end

    imh_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl_i),
      .left_i    (left_w),
      .left_gt_i (left_gt_w),
      .right_i   (right_w),
      .entry_o   (entries[i]),
      .gt_o      (gt[i])
    );
  end

  assign head_o = entries[0];
  assign full_o = entries[imh_pkg::HeapDepth-1].valid;

endmodule

`default_nettype wire

[rtl/core/indexed_max_heap_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake                 Payload
// in       in   in_valid_i / in_stall_o   opcode_i, height_i, label_i
// out      out  out_valid_o / out_stall_i max_height_o, is_empty_o, status_o
//
// A request passes the table lookup, one chain pass and the result load on its way
// to the output register. A rejected request skips the chain pass; a key update
// removes and inserts, so it makes two chain passes. in_stall_o is high until the
// cycle after the result load, so no request is taken before the last is done.
// Reset clears the chain, the presence bits and the count at once.
// A result held by out_stall_i holds the sequencer in its result step.
module indexed_max_heap_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        opcode_i,
  input  wire logic [15:0] height_i,
  input  wire logic [7:0]  label_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      max_height_o,
  output logic             is_empty_o,
  output logic [1:0]       status_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StLook   = 3'd1;
  localparam logic [2:0] StRemove = 3'd2;
  localparam logic [2:0] StInsert = 3'd3;
  localparam logic [2:0] StResult = 3'd4;

  logic [2:0] state_q, state_d;

  logic                         op_q;
  logic [imh_pkg::HeightW-1:0]  height_q;
  logic [7:0]                   label_q;
  logic [imh_pkg::LabelW-1:0]   lab_idx;
  logic                         lab_ok;
  logic                         in_xfer;

  logic                         present_q [imh_pkg::LabelCount];
  logic [imh_pkg::HeightW-1:0]  height_mem [imh_pkg::LabelCount];
  logic [imh_pkg::HeightW-1:0]  old_height_q;
  logic [imh_pkg::CountW-1:0]   count_q;
  logic [1:0]                   status_q, status_d;

  logic                         out_valid_q;
  logic [15:0]                  max_height_q;
  logic                         is_empty_q;
  logic [1:0]                   status_out_q;
  logic                         out_free;

  imh_pkg::chain_ctrl_t         chain_ctrl;
  imh_pkg::cell_t               head;
  logic                         chain_full;

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign lab_idx = imh_pkg::LabelW'(label_q);
  assign lab_ok  = (label_q != '0) && (32'(label_q) < imh_pkg::LabelCount);

  // Capture the request at its transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q     <= opcode_i;
      height_q <= imh_pkg::HeightW'(height_i);
      label_q  <= label_i;
    end
  end

  // Height of each label, kept so that its chain key can be rebuilt.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      old_height_q <= height_mem[imh_pkg::LabelW'(label_i)];
    end
    if (state_q == StInsert) begin
      height_mem[lab_idx] <= height_q;
    end
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          state_d = StLook;
        end
      end
      StLook: begin
        status_d = imh_pkg::StatusOk;
        priority if (!lab_ok) begin
          status_d = imh_pkg::StatusBadLabel;
          state_d  = StResult;
        end else if (op_q == imh_pkg::OpInsert) begin
          if (present_q[lab_idx]) begin
            state_d = StRemove;
          end else if (count_q == imh_pkg::CountW'(imh_pkg::HeapDepth)) begin
            status_d = imh_pkg::StatusFull;
            state_d  = StResult;
          end else begin
            state_d = StInsert;
          end
        end else if (present_q[lab_idx]) begin
          state_d = StRemove;
        end else begin
          status_d = imh_pkg::StatusNotPresent;
          state_d  = StResult;
        end
      end
      StRemove: begin
        state_d = (op_q == imh_pkg::OpInsert) ? StInsert : StResult;
      end
      StInsert: begin
        state_d = StResult;
      end
      StResult: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Command for the chain of slots.
  always_comb begin
    chain_ctrl.cmd = imh_pkg::CmdHold;
    chain_ctrl.key = {height_q, lab_idx};
    unique case (state_q)
      StRemove: begin
        chain_ctrl.cmd = imh_pkg::CmdRemove;
        chain_ctrl.key = {old_height_q, lab_idx};
      end
      StInsert: begin
        chain_ctrl.cmd = imh_pkg::CmdInsert;
      end
      default: begin
        chain_ctrl.cmd = imh_pkg::CmdHold;
      end
    endcase
  end

  imh_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (chain_ctrl),
    .head_o (head),
    .full_o (chain_full)
  );

  // State, entry count and presence bits. A key update removes and then
  // inserts, so the count comes back to where it was.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      status_q <= imh_pkg::StatusOk;
      count_q  <= '0;
      for (int i = 0; i < imh_pkg::LabelCount; i++) begin
        present_q[i] <= 1'b0;
      end
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      if (state_q == StRemove) begin
        count_q            <= count_q - imh_pkg::CountW'(1);
        present_q[lab_idx] <= 1'b0;
      end else if (state_q == StInsert) begin
        count_q            <= count_q + imh_pkg::CountW'(1);
        present_q[lab_idx] <= 1'b1;
      end
    end
  end

  // Output register: valid control with reset, payload without.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == StResult) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StResult) && out_free) begin
      max_height_q <= head.valid ? 16'(head.height) : '0;
      is_empty_q   <= (count_q == '0);
      status_out_q <= status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign max_height_o = max_height_q;
  assign is_empty_o   = is_empty_q;
  assign status_o     = status_out_q;

  // The chain is empty exactly when the count is zero and full exactly when it is at the heap depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head.valid == (count_q != '0))
    else $error("chain head validity disagrees with entry count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_full == (count_q == imh_pkg::CountW'(imh_pkg::HeapDepth)))
    else $error("chain tail occupancy disagrees with entry count");

  // An insert always leaves its label marked present.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StInsert) |=> present_q[lab_idx])
    else $error("inserted label not marked present");

  // A result appears only from the result step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StResult))
    else $error("result loaded outside the result step");

endmodule

`default_nettype wire
